// ===== src/ccr_pkg.sv =====
// shared constants, codes and helpers for the circle canvas rasteriser
package ccr_pkg;

    // canvas geometry
    localparam int MAX_SIDE  = 256;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int SIZE_W    = 9;

    // fixed point
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 24;
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DIFF_W    = COORD_W + 2;

    // operation codes carried in s_tuser
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // shape bytes
    localparam logic [7:0] SHAPE_FILLED  = 8'h43;
    localparam logic [7:0] SHAPE_OUTLINE = 8'h63;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG     = 2'd2;

    // reset values of the configuration registers
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1);
    localparam logic [7:0]        BG_RESET     = 8'd32;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CLEAR  = 9'b000000010,
        ST_R2     = 9'b000000100,
        ST_INNER  = 9'b000001000,
        ST_DY     = 9'b000010000,
        ST_SWEEP  = 9'b000100000,
        ST_FLUSH  = 9'b001000000,
        ST_RDMEM  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    // last index in use for a size register: zero acts as one, large clamps
    function automatic logic [SIDE_W-1:0] side_last(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] dec;
        dec = v - SIZE_W'(1);
        if (v == '0) begin
            side_last = '0;
        end else if (v > SIZE_W'(MAX_SIDE)) begin
            side_last = SIDE_W'(MAX_SIDE - 1);
        end else begin
            side_last = dec[SIDE_W-1:0];
        end
    endfunction

endpackage

// ===== src/circle_canvas_rasterizer.sv =====
// circle canvas rasteriser: byte canvas with clear, circle draw and cell read
//
// Channels: the s_ stream carries one operation per item, s_tuser selects it
// (clear, draw circle, read cell) and s_tdata holds centre, radius, shape,
// paint byte and read coordinates. The m_ stream returns exactly one item per
// operation: m_tuser is the error flag, m_tdata the byte read (zero otherwise).
// The configuration port writes canvas width, height and background byte; the
// user writes it only while no operation is in flight, which the block itself
// does not enforce. A clear writes one cell per cycle through the single
// memory write port. A draw uses one shared 24x24 squarer that forms r^2,
// (r-1)^2, one dy^2 per row and one dx^2 per cell, followed by one
// compare-and-write stage. A read goes through the registered memory read.
// Errors go straight to the finishing step.
// Only one item is worked on at a time; s_tready is high only when idle.
// A finished result waits in the output register; while the receiver stalls
// with that register still full, the block holds in its finishing step and
// takes no new item.
// Reset clears the sequencer and output valid and loads the register
// defaults (1 x 1 canvas, space background); canvas contents are undefined
// until a clear has written them.
module circle_canvas_rasterizer (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data,
    // operation items
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x[23:0], center_y[47:24], radius[71:48], shape_type[79:72],
    // paint_char[87:80], cell_column[95:88], cell_row[103:96]
    input  logic [103:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_value[7:0]
    output logic [7:0]   m_tdata,
    // status[0]
    output logic [0:0]   m_tuser
);

    localparam int SW = ccr_pkg::SIDE_W;

    // input field slices
    logic signed [ccr_pkg::COORD_W-1:0] in_cx, in_cy, in_r;
    logic [7:0]    in_shape, in_paint;
    logic [SW-1:0] in_col, in_row;

    assign in_cx    = s_tdata[23:0];
    assign in_cy    = s_tdata[47:24];
    assign in_r     = s_tdata[71:48];
    assign in_shape = s_tdata[79:72];
    assign in_paint = s_tdata[87:80];
    assign in_col   = s_tdata[95:88];
    assign in_row   = s_tdata[103:96];

    // configuration registers
    logic [ccr_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [7:0]                 bg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ccr_pkg::WIDTH_RESET;
            height_reg <= ccr_pkg::HEIGHT_RESET;
            bg_reg     <= ccr_pkg::BG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ccr_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                ccr_pkg::REG_HEIGHT: height_reg <= cfg_data;
                ccr_pkg::REG_BG:     bg_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer and item state
    ccr_pkg::state_t state_reg, state_next;
    logic [SW-1:0] x_reg, x_next, y_reg, y_next;
    logic [SW-1:0] x_last_reg, x_last_next, y_last_reg, y_last_next;
    logic signed [ccr_pkg::COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next, r_reg, r_next;
    logic [7:0] paint_reg, paint_next;
    logic       filled_reg, filled_next;
    logic       err_reg, err_next;
    logic       is_read_reg, is_read_next;
    logic       inner_ok_reg, inner_ok_next;
    logic [ccr_pkg::SQ_W-1:0] r2_reg, r2_next, inner2_reg, inner2_next;
    logic [ccr_pkg::SQ_W-1:0] dy2_reg, dy2_next, prod_reg, prod_next;
    logic                       pipe_vld_reg, pipe_vld_next;
    logic [ccr_pkg::ADDR_W-1:0] pipe_addr_reg, pipe_addr_next;

    // output register
    logic       m_vld_reg, m_vld_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_err_reg, m_err_next;

    // canvas memory
    logic [7:0] canvas_mem [ccr_pkg::CELLS];
    logic [7:0] rd_data_reg;
    logic       wr_en;
    logic [ccr_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0] wr_data;

    // shared subtract / abs / squarer unit
    logic signed [ccr_pkg::DIFF_W-1:0] diff_a, diff_b, diff;
    logic [ccr_pkg::DIFF_W-1:0] diff_abs;
    logic [SW-1:0]              coord_sel;
    logic signed [ccr_pkg::COORD_W-1:0] centre_sel, r_minus;
    logic [ccr_pkg::MAG_W-1:0]  mag;
    logic [ccr_pkg::SQ_W-1:0]   sq;

    assign r_minus    = r_reg - ccr_pkg::COORD_W'(1 << ccr_pkg::FRAC_BITS);
    assign coord_sel  = (state_reg == ccr_pkg::ST_DY) ? y_reg : x_reg;
    assign centre_sel = (state_reg == ccr_pkg::ST_DY) ? cy_reg : cx_reg;
    assign diff_a = {{(ccr_pkg::DIFF_W - SW - ccr_pkg::FRAC_BITS){1'b0}}, coord_sel,
                     {ccr_pkg::FRAC_BITS{1'b0}}};
    assign diff_b = {{(ccr_pkg::DIFF_W - ccr_pkg::COORD_W){centre_sel[ccr_pkg::COORD_W-1]}},
                     centre_sel};
    assign diff     = diff_a - diff_b;
    assign diff_abs = diff[ccr_pkg::DIFF_W-1] ? ccr_pkg::DIFF_W'(-diff) : diff;

    // operand select for the squarer
    always_comb begin
        priority case (1'b1)
            state_reg == ccr_pkg::ST_R2:
                mag = r_reg;
            state_reg == ccr_pkg::ST_INNER:
                mag = r_minus[ccr_pkg::COORD_W-1] ? '0 : r_minus;
            default:
                mag = diff_abs[ccr_pkg::MAG_W-1:0];
        endcase
    end

    assign sq = mag * mag;

    // compare stage: squared distance against squared radii
    logic [ccr_pkg::SQ_W:0] d2;
    logic in_disc, border, hit;

    assign d2      = {1'b0, prod_reg} + {1'b0, dy2_reg};
    assign in_disc = d2 <= {1'b0, r2_reg};
    assign border  = in_disc && (!inner_ok_reg || d2 > {1'b0, inner2_reg});
    assign hit     = pipe_vld_reg && ((filled_reg && in_disc) || border);

    // memory write port shared by clear and draw
    always_comb begin
        if (state_reg == ccr_pkg::ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = {y_reg, x_reg};
            wr_data = bg_reg;
        end else begin
            wr_en   = hit;
            wr_addr = pipe_addr_reg;
            wr_data = paint_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            canvas_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= canvas_mem[{y_reg, x_reg}];
    end

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x_last_next    = x_last_reg;
        y_last_next    = y_last_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        r_next         = r_reg;
        paint_next     = paint_reg;
        filled_next    = filled_reg;
        err_next       = err_reg;
        is_read_next   = is_read_reg;
        inner_ok_next  = inner_ok_reg;
        r2_next        = r2_reg;
        inner2_next    = inner2_reg;
        dy2_next       = dy2_reg;
        prod_next      = prod_reg;
        pipe_vld_next  = 1'b0;
        pipe_addr_next = pipe_addr_reg;
        m_vld_next     = m_vld_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_err_next     = m_err_reg;

        unique case (state_reg)
            ccr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    x_last_next  = ccr_pkg::side_last(width_reg);
                    y_last_next  = ccr_pkg::side_last(height_reg);
                    cx_next      = in_cx;
                    cy_next      = in_cy;
                    r_next       = in_r;
                    paint_next   = in_paint;
                    filled_next  = (in_shape == ccr_pkg::SHAPE_FILLED);
                    err_next     = 1'b0;
                    is_read_next = 1'b0;
                    x_next       = '0;
                    y_next       = '0;
                    unique case (s_tuser)
                        ccr_pkg::FUNC_CLEAR: state_next = ccr_pkg::ST_CLEAR;
                        ccr_pkg::FUNC_DRAW: begin
                            if (in_r <= 0 || (in_shape != ccr_pkg::SHAPE_FILLED &&
                                              in_shape != ccr_pkg::SHAPE_OUTLINE)) begin
                                err_next   = 1'b1;
                                state_next = ccr_pkg::ST_FINISH;
                            end else begin
                                state_next = ccr_pkg::ST_R2;
                            end
                        end
                        ccr_pkg::FUNC_READ: begin
                            if (in_col > x_last_next || in_row > y_last_next) begin
                                err_next   = 1'b1;
                                state_next = ccr_pkg::ST_FINISH;
                            end else begin
                                is_read_next = 1'b1;
                                x_next       = in_col;
                                y_next       = in_row;
                                state_next   = ccr_pkg::ST_RDMEM;
                            end
                        end
                        default: begin
                            err_next   = 1'b1;
                            state_next = ccr_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            // fill every cell in use with the background byte
            ccr_pkg::ST_CLEAR: begin
                if (x_reg == x_last_reg) begin
                    x_next = '0;
                    if (y_reg == y_last_reg) begin
                        state_next = ccr_pkg::ST_FINISH;
                    end else begin
                        y_next = y_reg + 1'b1;
                    end
                end else begin
                    x_next = x_reg + 1'b1;
                end
            end
            ccr_pkg::ST_R2: begin
                r2_next    = sq;
                state_next = ccr_pkg::ST_INNER;
            end
            ccr_pkg::ST_INNER: begin
                inner2_next   = sq;
                inner_ok_next = !r_minus[ccr_pkg::COORD_W-1];
                state_next    = ccr_pkg::ST_DY;
            end
            // row term; the last cell of the previous row still uses the old one
            ccr_pkg::ST_DY: begin
                dy2_next   = sq;
                state_next = ccr_pkg::ST_SWEEP;
            end
            // one cell per cycle into the compare stage within a row; each new row passes through ST_DY first
            ccr_pkg::ST_SWEEP: begin
                prod_next      = sq;
                pipe_vld_next  = 1'b1;
                pipe_addr_next = {y_reg, x_reg};
                if (x_reg == x_last_reg) begin
                    x_next = '0;
                    if (y_reg == y_last_reg) begin
                        state_next = ccr_pkg::ST_FLUSH;
                    end else begin
                        y_next     = y_reg + 1'b1;
                        state_next = ccr_pkg::ST_DY;
                    end
                end else begin
                    x_next = x_reg + 1'b1;
                end
            end
            ccr_pkg::ST_FLUSH: state_next = ccr_pkg::ST_FINISH;
            ccr_pkg::ST_RDMEM: state_next = ccr_pkg::ST_FINISH;
            // hand the result to the output register once it is free
            ccr_pkg::ST_FINISH: begin
                if (!m_vld_reg || m_tready) begin
                    m_vld_next  = 1'b1;
                    m_err_next  = err_reg;
                    m_data_next = is_read_reg ? rd_data_reg : 8'd0;
                    state_next  = ccr_pkg::ST_IDLE;
                end
            end
            default: state_next = ccr_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ccr_pkg::ST_IDLE;
            pipe_vld_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pipe_vld_reg <= pipe_vld_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        x_last_reg    <= x_last_next;
        y_last_reg    <= y_last_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        r_reg         <= r_next;
        paint_reg     <= paint_next;
        filled_reg    <= filled_next;
        err_reg       <= err_next;
        is_read_reg   <= is_read_next;
        inner_ok_reg  <= inner_ok_next;
        r2_reg        <= r2_next;
        inner2_reg    <= inner2_next;
        dy2_reg       <= dy2_next;
        prod_reg      <= prod_next;
        pipe_addr_reg <= pipe_addr_next;
        m_data_reg    <= m_data_next;
        m_err_reg     <= m_err_next;
    end

    assign s_tready = (state_reg == ccr_pkg::ST_IDLE);
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

endmodule
